// File: rtl/core/kpl_pkg.sv
// ----------------------------------------------------------------------------
// kpl_pkg
// Types and constants shared by the keypad passcode lock core.
// ----------------------------------------------------------------------------
package kpl_pkg;

  // event opcodes
  localparam logic [2:0] EV_MOVE   = 3'd0;
  localparam logic [2:0] EV_PRESS  = 3'd1;
  localparam logic [2:0] EV_BACK   = 3'd2;
  localparam logic [2:0] EV_TICK   = 3'd3;
  localparam logic [2:0] EV_TOGGLE = 3'd4;

  typedef enum logic [1:0] {
    MODE_LOGIN = 2'd0,
    MODE_DESK  = 2'd1,
    MODE_LOCK  = 2'd2,
    MODE_APP   = 2'd3
  } mode_t;

  localparam logic [1:0] VERDICT_NONE   = 2'd0;
  localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
  localparam logic [1:0] VERDICT_WRONG  = 2'd2;
  localparam logic [1:0] VERDICT_LOCKED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_PASSCODE     = 2'd0;
  localparam logic [1:0] CFG_MAX_FAILURES = 2'd1;
  localparam logic [1:0] CFG_LOCK_SECONDS = 2'd2;
  localparam logic [1:0] CFG_ICON_COUNT   = 2'd3;

  localparam logic [15:0] PASSCODE_RST     = 16'h1234;
  localparam logic [3:0]  MAX_FAILURES_RST = 4'd3;
  localparam logic [7:0]  LOCK_SECONDS_RST = 8'd30;
  localparam logic [2:0]  ICON_COUNT_RST   = 3'd4;

  // keypad geometry: 3x4 cells of 60x45 at (30,120)
  localparam int PAD_COLS = 3;
  localparam int PAD_ROWS = 4;
  localparam int PAD_W    = 60;
  localparam int PAD_H    = 45;
  localparam int PAD_X    = 30;
  localparam int PAD_Y    = 120;

  localparam logic [3:0] CELL_HOME  = 4'd4;
  localparam logic [3:0] CELL_STAR  = 4'd9;
  localparam logic [3:0] CELL_ZERO  = 4'd10;
  localparam logic [3:0] CELL_ERASE = 4'd11;

  // desktop icon tiles
  localparam int TILE_COLS = 3;
  localparam int TILE_W    = 68;
  localparam int TILE_H    = 60;
  localparam int TILE_X    = 18;
  localparam int TILE_Y    = 60;
  localparam int TILE_DX   = 73;
  localparam int TILE_DY   = 80;

  localparam logic [3:0] FAIL_MAX = 4'd15;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] cursor_x;
    logic [8:0] cursor_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0] screen_mode;
    logic [2:0] digits_entered;
    logic [3:0] key_hover;
    logic [2:0] icon_hover;
    logic [1:0] verdict;
    logic       app_launch;
    logic [2:0] app_index;
    logic       forward_to_app;
    logic [7:0] lock_left;
    logic [3:0] fail_total;
  } out_item_t;

  // classified event between front and back
  typedef struct packed {
    logic [2:0] kind;
    logic       cell_hit;
    logic [3:0] pad_key;
    logic       icon_hit;
    logic [2:0] icon;
  } cls_t;

  typedef struct packed {
    logic [15:0] passcode;
    logic [3:0]  max_failures;
    logic [7:0]  lock_seconds;
    logic [2:0]  icon_count;
  } cfg_t;

endpackage

// File: rtl/core/kpl_front.sv
// ----------------------------------------------------------------------------
// kpl_front
// Hit-tests the cursor against the keypad and the desktop icons.
// ----------------------------------------------------------------------------
module kpl_front #(
  parameter int ICON_SLOTS = 6
) (
  input  kpl_pkg::in_item_t item,
  input  logic [2:0]        icon_count,
  output kpl_pkg::cls_t     cls
);

  logic [9:0]            x_ext;
  logic [9:0]            y_ext;
  logic                  in_pad;
  logic [1:0]            col;
  logic [1:0]            row;
  logic [ICON_SLOTS-1:0] icon_vec;
  logic [2:0]            icon_sel;

  assign x_ext = {2'b00, item.cursor_x};
  assign y_ext = {1'b0, item.cursor_y};

  assign in_pad = (x_ext >= 10'(kpl_pkg::PAD_X))
               && (x_ext <  10'(kpl_pkg::PAD_X + kpl_pkg::PAD_COLS * kpl_pkg::PAD_W))
               && (y_ext >= 10'(kpl_pkg::PAD_Y))
               && (y_ext <  10'(kpl_pkg::PAD_Y + kpl_pkg::PAD_ROWS * kpl_pkg::PAD_H));

  always_comb begin
    if (x_ext < 10'(kpl_pkg::PAD_X + kpl_pkg::PAD_W)) begin
      col = 2'd0;
    end else if (x_ext < 10'(kpl_pkg::PAD_X + 2 * kpl_pkg::PAD_W)) begin
      col = 2'd1;
    end else begin
      col = 2'd2;
    end
    if (y_ext < 10'(kpl_pkg::PAD_Y + kpl_pkg::PAD_H)) begin
      row = 2'd0;
    end else if (y_ext < 10'(kpl_pkg::PAD_Y + 2 * kpl_pkg::PAD_H)) begin
      row = 2'd1;
    end else if (y_ext < 10'(kpl_pkg::PAD_Y + 3 * kpl_pkg::PAD_H)) begin
      row = 2'd2;
    end else begin
      row = 2'd3;
    end
  end

  genvar g;
  generate
    for (g = 0; g < ICON_SLOTS; g++) begin : g_icon
      localparam int IX = kpl_pkg::TILE_X + (g % kpl_pkg::TILE_COLS) * kpl_pkg::TILE_DX;
      localparam int IY = kpl_pkg::TILE_Y + (g / kpl_pkg::TILE_COLS) * kpl_pkg::TILE_DY;
      assign icon_vec[g] = (3'(g) < icon_count)
                        && (x_ext >= 10'(IX) && x_ext <= 10'(IX + kpl_pkg::TILE_W))
                        && (y_ext >= 10'(IY) && y_ext <= 10'(IY + kpl_pkg::TILE_H));
    end
  endgenerate

  // lowest index wins
  always_comb begin
    icon_sel = 3'd0;
    for (int i = ICON_SLOTS - 1; i >= 0; i--) begin
      if (icon_vec[i]) icon_sel = 3'(i);
    end
  end

  always_comb begin
    cls.kind     = item.event_kind;
    cls.cell_hit = in_pad;
    cls.pad_key  = 4'({row, 1'b0}) + 4'(row) + 4'(col);
    cls.icon_hit = |icon_vec;
    cls.icon     = icon_sel;
  end

endmodule

// File: rtl/core/kpl_queue.sv
// ----------------------------------------------------------------------------
// kpl_queue
// Two-entry queue of classified events between front and back.
// ----------------------------------------------------------------------------
module kpl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  kpl_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output kpl_pkg::cls_t pop_data
);

  localparam int PW = $clog2(kpl_pkg::QDEPTH);
  localparam int CW = $clog2(kpl_pkg::QDEPTH + 1);

  kpl_pkg::cls_t mem_r [kpl_pkg::QDEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(kpl_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? PW'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt = pop  ? PW'(rptr_r + 1'b1) : rptr_r;
    cnt_nxt  = CW'(cnt_r + CW'(push) - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

endmodule

// File: rtl/core/kpl_back.sv
// ----------------------------------------------------------------------------
// kpl_back
// Screen state machine: login, lockout, desktop and app, plus result register.
// ----------------------------------------------------------------------------
module kpl_back #(
  parameter int CODE_LEN = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kpl_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  kpl_pkg::cls_t      q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output kpl_pkg::out_item_t out_data
);

  localparam int IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;

  kpl_pkg::mode_t     mode_r, mode_nxt;
  logic [3:0]         entry_r [CODE_LEN];
  logic [2:0]         count_r, count_nxt;
  logic [3:0]         fail_r, fail_nxt;
  logic [7:0]         lock_r, lock_nxt;
  logic [3:0]         hcell_r, hcell_nxt;
  logic [2:0]         hicon_r, hicon_nxt;
  logic [2:0]         app_r, app_nxt;
  logic               out_valid_r, out_valid_nxt;
  kpl_pkg::out_item_t out_r, out_nxt;

  logic               fire;
  logic               wr_en;
  logic [3:0]         digit;
  logic [3:0]         fail_sat;
  logic [7:0]         lock_dec;
  logic [CODE_LEN-1:0] match;
  logic [1:0]         verdict;
  logic               launch;
  logic               fwd;

  assign fire      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign digit    = (q_item.pad_key == kpl_pkg::CELL_ZERO) ? 4'd0
                                                           : 4'(q_item.pad_key + 4'd1);
  assign fail_sat = (fail_r == kpl_pkg::FAIL_MAX) ? fail_r : 4'(fail_r + 4'd1);
  assign lock_dec = (lock_r != 8'd0) ? 8'(lock_r - 8'd1) : 8'd0;

  // per-digit compare; the last digit is the one arriving now
  genvar g;
  generate
    for (g = 0; g < CODE_LEN; g++) begin : g_match
      localparam int NIB = CODE_LEN - 1 - g;
      logic [3:0] want;
      if (NIB < 4) begin : g_in
        assign want = cfg.passcode[NIB*4 +: 4];
      end else begin : g_out
        assign want = 4'd0;
      end
      if (g == CODE_LEN - 1) begin : g_last
        assign match[g] = (digit == want);
      end else begin : g_held
        assign match[g] = (entry_r[g] == want);
      end
    end
  endgenerate

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    fail_nxt  = fail_r;
    lock_nxt  = lock_r;
    hcell_nxt = hcell_r;
    hicon_nxt = hicon_r;
    app_nxt   = app_r;
    verdict   = kpl_pkg::VERDICT_NONE;
    launch    = 1'b0;
    fwd       = 1'b0;
    wr_en     = 1'b0;

    case (mode_r)
      kpl_pkg::MODE_LOGIN: begin
        if (q_item.kind == kpl_pkg::EV_MOVE) begin
          if (q_item.cell_hit) hcell_nxt = q_item.pad_key;
        end else if (q_item.kind == kpl_pkg::EV_BACK) begin
          count_nxt = 3'd0;
        end else if (q_item.kind == kpl_pkg::EV_PRESS && q_item.cell_hit) begin
          if (q_item.pad_key == kpl_pkg::CELL_ERASE) begin
            if (count_r != 3'd0) count_nxt = 3'(count_r - 3'd1);
          end else if (q_item.pad_key != kpl_pkg::CELL_STAR) begin
            if (count_r == 3'(CODE_LEN - 1)) begin
              count_nxt = 3'd0;
              if (&match) begin
                verdict   = kpl_pkg::VERDICT_ACCEPT;
                mode_nxt  = kpl_pkg::MODE_DESK;
                hicon_nxt = 3'd0;
              end else begin
                fail_nxt = fail_sat;
                if (fail_sat >= cfg.max_failures) begin
                  verdict  = kpl_pkg::VERDICT_LOCKED;
                  mode_nxt = kpl_pkg::MODE_LOCK;
                  lock_nxt = cfg.lock_seconds;
                end else begin
                  verdict = kpl_pkg::VERDICT_WRONG;
                end
              end
            end else begin
              wr_en     = 1'b1;
              count_nxt = 3'(count_r + 3'd1);
            end
          end
        end
      end
      kpl_pkg::MODE_LOCK: begin
        if (q_item.kind == kpl_pkg::EV_TICK) begin
          lock_nxt = lock_dec;
          if (lock_dec == 8'd0) begin
            fail_nxt  = 4'd0;
            mode_nxt  = kpl_pkg::MODE_LOGIN;
            count_nxt = 3'd0;
            hcell_nxt = kpl_pkg::CELL_HOME;
          end
        end
      end
      kpl_pkg::MODE_DESK: begin
        if (q_item.kind == kpl_pkg::EV_BACK) begin
          fail_nxt  = 4'd0;
          mode_nxt  = kpl_pkg::MODE_LOGIN;
          count_nxt = 3'd0;
          hcell_nxt = kpl_pkg::CELL_HOME;
        end else if (q_item.kind == kpl_pkg::EV_MOVE) begin
          if (q_item.icon_hit) hicon_nxt = q_item.icon;
        end else if (q_item.kind == kpl_pkg::EV_PRESS) begin
          if (q_item.icon_hit) begin
            app_nxt  = q_item.icon;
            mode_nxt = kpl_pkg::MODE_APP;
            launch   = 1'b1;
          end
        end
      end
      kpl_pkg::MODE_APP: begin
        if (q_item.kind == kpl_pkg::EV_BACK) begin
          mode_nxt  = kpl_pkg::MODE_DESK;
          hicon_nxt = 3'd0;
        end else if (q_item.kind <= kpl_pkg::EV_TOGGLE) begin
          fwd = 1'b1;
        end
      end
      default: begin
        mode_nxt = kpl_pkg::MODE_LOGIN;
      end
    endcase

    out_nxt.screen_mode    = mode_nxt;
    out_nxt.digits_entered = count_nxt;
    out_nxt.key_hover      = hcell_nxt;
    out_nxt.icon_hover     = hicon_nxt;
    out_nxt.verdict        = verdict;
    out_nxt.app_launch     = launch;
    out_nxt.app_index      = (mode_nxt == kpl_pkg::MODE_APP) ? app_nxt : 3'd0;
    out_nxt.forward_to_app = fwd;
    out_nxt.lock_left      = (mode_nxt == kpl_pkg::MODE_LOCK) ? lock_nxt : 8'd0;
    out_nxt.fail_total     = fail_nxt;

    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= kpl_pkg::MODE_LOGIN;
      count_r     <= 3'd0;
      fail_r      <= 4'd0;
      lock_r      <= 8'd0;
      hcell_r     <= kpl_pkg::CELL_HOME;
      hicon_r     <= 3'd0;
      app_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        mode_r  <= mode_nxt;
        count_r <= count_nxt;
        fail_r  <= fail_nxt;
        lock_r  <= lock_nxt;
        hcell_r <= hcell_nxt;
        hicon_r <= hicon_nxt;
        app_r   <= app_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_r <= out_nxt;
    if (fire && wr_en) entry_r[count_r[IDX_W-1:0]] <= digit;
  end

endmodule

// File: rtl/core/keypad_passcode_lock_core.sv
// ----------------------------------------------------------------------------
// keypad_passcode_lock_core
// Pointer-driven passcode keypad with lockout, desktop and app launcher.
// ----------------------------------------------------------------------------
// Takes one pointer event per clock while the queue has room and returns one
// status result per event, in order. An event is hit-tested in the front
// stage, waits in a two-entry queue, and is executed by the screen state
// machine whose result sits in an output register: the result is registered
// first in the queue and then in the output register, and throughput is one
// event per cycle while the result side keeps up. The queue lets input
// transfers continue for two events while the result side stalls.
// Configuration writes are always ready and must only be issued while no
// event is in flight.
module keypad_passcode_lock_core #(
  parameter int CODE_LEN   = 4,
  parameter int ICON_SLOTS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kpl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kpl_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  kpl_pkg::cfg_t cfg_r, cfg_nxt;
  kpl_pkg::cls_t front_cls;
  kpl_pkg::cls_t q_item;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          in_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_xfer   = in_valid && in_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        kpl_pkg::CFG_PASSCODE:     cfg_nxt.passcode     = cfg_data;
        kpl_pkg::CFG_MAX_FAILURES: cfg_nxt.max_failures = cfg_data[3:0];
        kpl_pkg::CFG_LOCK_SECONDS: cfg_nxt.lock_seconds = cfg_data[7:0];
        kpl_pkg::CFG_ICON_COUNT:   cfg_nxt.icon_count   = cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.passcode     <= kpl_pkg::PASSCODE_RST;
      cfg_r.max_failures <= kpl_pkg::MAX_FAILURES_RST;
      cfg_r.lock_seconds <= kpl_pkg::LOCK_SECONDS_RST;
      cfg_r.icon_count   <= kpl_pkg::ICON_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  kpl_front #(
    .ICON_SLOTS(ICON_SLOTS)
  ) u_front (
    .item      (in_data),
    .icon_count(cfg_r.icon_count),
    .cls       (front_cls)
  );

  kpl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_xfer),
    .push_data(front_cls),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_data (q_item)
  );

  kpl_back #(
    .CODE_LEN(CODE_LEN)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // an event entering an empty pipeline shows up as a result after the queue and the output register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !q_valid && !out_valid) |-> ##2 out_valid)
    else $error("result missing after transfer into empty pipeline");

  a_lock_left: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.lock_left != 8'd0) |->
      (out_data.screen_mode == kpl_pkg::MODE_LOCK))
    else $error("lockout count outside lockout");

  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.app_launch) |->
      (out_data.screen_mode == kpl_pkg::MODE_APP && !out_data.forward_to_app))
    else $error("launch without app in foreground");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.verdict == kpl_pkg::VERDICT_ACCEPT) |->
      (out_data.screen_mode == kpl_pkg::MODE_DESK && out_data.digits_entered == 3'd0))
    else $error("accepted passcode did not open the desktop");

endmodule
